>>> rtl/core/gbn_pkg.sv
package gbn_pkg;

    // Default build-time sizes
    localparam int WINDOW_SLOTS_DEF = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Field widths of the channel words
    localparam int MODE_W    = 2;
    localparam int PAYLOAD_W = 64;
    localparam int SEQ_W     = 8;
    localparam int MOD_W     = 9;
    localparam int KIND_W    = 2;
    localparam int TIMER_W   = 2;

    // Sequence modulus register
    localparam logic [MOD_W-1:0] MOD_RESET = 9'd16;
    localparam logic [MOD_W-1:0] MOD_MAX   = 9'd256;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HANDLED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    // Timer requests
    localparam logic [TIMER_W-1:0] TIMER_NONE    = 2'd0;
    localparam logic [TIMER_W-1:0] TIMER_START   = 2'd1;
    localparam logic [TIMER_W-1:0] TIMER_STOP    = 2'd2;
    localparam logic [TIMER_W-1:0] TIMER_RESTART = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [PAYLOAD_W-1:0] payload;
        logic [SEQ_W-1:0]     ack_number;
        logic                 ack_valid;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SEQ_W-1:0]     packet_seq;
        logic [PAYLOAD_W-1:0] packet_data;
        logic [TIMER_W-1:0]   timer_action;
        logic                 window_moved;
        logic                 last;
    } t_out_word;

endpackage

>>> rtl/core/gbn_ifs.sv
// Input item channel
interface gbn_in_if;
    logic               valid;
    logic               ready;
    gbn_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface gbn_out_if;
    logic               valid;
    logic               ready;
    gbn_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface gbn_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [gbn_pkg::MOD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/gbn_slot_mem.sv
module gbn_slot_mem #(
    parameter int DEPTH = gbn_pkg::WINDOW_SLOTS_DEF,
    parameter int WIDTH = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/gbn_mod_unit.sv
module gbn_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gbn_pkg::MOD_W-1:0]     i_dividend,
    input  logic [gbn_pkg::MOD_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [gbn_pkg::SEQ_W-1:0]     o_rem
);

    localparam int STEP_W = $clog2(gbn_pkg::MOD_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(gbn_pkg::MOD_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [gbn_pkg::MOD_W-1:0]   r_dvd;
    logic [gbn_pkg::SEQ_W-1:0]   r_rem;
    logic [gbn_pkg::MOD_W-1:0]   trial;
    logic [gbn_pkg::MOD_W-1:0]   diff;
    logic                        fits;

    // One restoring step per cycle, dividend bits taken MSB first
    assign trial = {r_rem, r_dvd[gbn_pkg::MOD_W-1]};
    assign fits  = (trial >= i_divisor);
    assign diff  = trial - i_divisor;

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and shifting dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[gbn_pkg::MOD_W-2:0], 1'b0};
            r_rem <= fits ? diff[gbn_pkg::SEQ_W-1:0] : trial[gbn_pkg::SEQ_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/gbn_ctrl.sv
module gbn_ctrl #(
    parameter int WINDOW_SLOTS = gbn_pkg::WINDOW_SLOTS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [gbn_pkg::MOD_W-1:0] i_modulus,
    input  logic                      i_mod_changed,
    gbn_in_if.sink                    i_in,
    gbn_out_if.source                 o_out
);

    localparam int IW = $clog2(WINDOW_SLOTS);
    localparam int CW = IW + 1;
    localparam int SW = gbn_pkg::SEQ_W;
    localparam int MW = gbn_pkg::MOD_W;
    localparam logic [CW-1:0] SLOTS     = CW'(WINDOW_SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW_SLOTS - 1);
    localparam logic [IW-1:0] FULL_CNT  = IW'(WINDOW_SLOTS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_REM_OS = 3'd2;
    localparam logic [2:0] S_REM_NX = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;
    localparam logic [2:0] S_TX     = 3'd5;

    logic [2:0]         r_state,       n_state;
    gbn_pkg::t_in_word  r_item,        n_item;
    logic [IW-1:0]      r_oldest_slot, n_oldest_slot;
    logic [IW-1:0]      r_next_slot,   n_next_slot;
    logic [SW-1:0]      r_oldest_seq,  n_oldest_seq;
    logic [SW-1:0]      r_os,          n_os;
    logic [SW-1:0]      r_next_seq,    n_next_seq;
    logic               r_seq_ok,      n_seq_ok;
    logic [IW-1:0]      r_tx_slot,     n_tx_slot;
    logic [SW-1:0]      r_tx_seq,      n_tx_seq;
    logic [IW-1:0]      r_tx_left,     n_tx_left;
    logic               r_tx_first,    n_tx_first;
    logic               r_out_valid,   n_out_valid;
    gbn_pkg::t_out_word r_out,         n_out;

    logic [CW-1:0]           cnt_sum;
    logic [CW-1:0]           cnt_wide;
    logic [IW-1:0]           cnt;
    logic                    out_free;
    logic                    rem_start;
    logic [MW-1:0]           rem_dvd;
    logic                    rem_done;
    logic [SW-1:0]           rem;
    logic                    mem_we;
    logic                    mem_re;
    logic [IW-1:0]           mem_raddr;
    logic [PAYLOAD_BITS-1:0] mem_rdata;
    logic                    ack_in_range;
    logic [MW:0]             d_sum;
    logic [MW:0]             d_wide;
    logic [MW-1:0]           ack_dist;
    logic                    ack_hit;
    logic [CW-1:0]           adv_sum;
    logic [CW-1:0]           adv_wrap;
    logic [IW-1:0]           new_oldest;
    logic [IW-1:0]           after_oldest;
    logic [MW-1:0]           ack_plus;
    logic [SW-1:0]           ack_next;
    logic [MW-1:0]           nseq_plus;
    logic [SW-1:0]           nseq_inc;
    logic [MW-1:0]           tseq_plus;
    logic [SW-1:0]           tseq_inc;
    logic [IW-1:0]           nslot_inc;
    logic [IW-1:0]           tslot_inc;
    logic                    tx_last;

    // Outstanding count from the ring pointers
    assign cnt_sum  = {1'b0, r_next_slot} + SLOTS - {1'b0, r_oldest_slot};
    assign cnt_wide = (cnt_sum >= SLOTS) ? cnt_sum - SLOTS : cnt_sum;
    assign cnt      = cnt_wide[IW-1:0];

    assign out_free = !r_out_valid || o_out.ready;

    // Distance from the oldest sequence number to the acked one
    assign ack_in_range = ({1'b0, r_item.ack_number} < i_modulus);
    assign d_sum  = (MW+1)'(r_item.ack_number) + (MW+1)'(i_modulus) - (MW+1)'(r_os);
    assign d_wide = (d_sum >= (MW+1)'(i_modulus)) ? d_sum - (MW+1)'(i_modulus) : d_sum;
    assign ack_dist = d_wide[MW-1:0];
    assign ack_hit  = r_item.ack_valid && ack_in_range && (ack_dist < MW'(cnt));

    // Slide the oldest slot past the acked packet
    assign adv_sum  = {1'b0, r_oldest_slot} + CW'(ack_dist[IW-1:0]) + CW'(1);
    assign adv_wrap = (adv_sum >= SLOTS) ? adv_sum - SLOTS : adv_sum;
    assign new_oldest   = adv_wrap[IW-1:0];
    assign after_oldest = ack_hit ? new_oldest : r_oldest_slot;

    // Sequence increments with wrap at the modulus
    assign ack_plus  = {1'b0, r_item.ack_number} + MW'(1);
    assign ack_next  = (ack_plus == i_modulus) ? '0 : ack_plus[SW-1:0];
    assign nseq_plus = {1'b0, r_next_seq} + MW'(1);
    assign nseq_inc  = (nseq_plus == i_modulus) ? '0 : nseq_plus[SW-1:0];
    assign tseq_plus = {1'b0, r_tx_seq} + MW'(1);
    assign tseq_inc  = (tseq_plus == i_modulus) ? '0 : tseq_plus[SW-1:0];

    // Slot increments with wrap at the ring size
    assign nslot_inc = (r_next_slot == LAST_SLOT) ? '0 : r_next_slot + 1'b1;
    assign tslot_inc = (r_tx_slot == LAST_SLOT) ? '0 : r_tx_slot + 1'b1;

    assign tx_last = (r_tx_left == IW'(1));

    gbn_slot_mem #(
        .DEPTH (WINDOW_SLOTS),
        .WIDTH (PAYLOAD_BITS)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_next_slot),
        .i_wr_data (r_item.payload[PAYLOAD_BITS-1:0]),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    gbn_mod_unit u_mod_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dvd),
        .i_divisor  (i_modulus),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_oldest_slot = r_oldest_slot;
        n_next_slot   = r_next_slot;
        n_oldest_seq  = r_oldest_seq;
        n_os          = r_os;
        n_next_seq    = r_next_seq;
        n_seq_ok      = r_seq_ok;
        n_tx_slot     = r_tx_slot;
        n_tx_seq      = r_tx_seq;
        n_tx_left     = r_tx_left;
        n_tx_first    = r_tx_first;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out         = r_out;
        rem_start     = 1'b0;
        rem_dvd       = {1'b0, r_oldest_seq};
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = r_oldest_slot;
        i_in.ready    = 1'b0;

        // Cached sequence numbers no longer hold under a new modulus
        if (i_mod_changed) begin
            n_seq_ok = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_item  = i_in.data;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_seq_ok) begin
                    n_state = S_EXEC;
                end else begin
                    rem_start = 1'b1;
                    n_state   = S_REM_OS;
                end
            end
            S_REM_OS: begin
                if (rem_done) begin
                    n_os      = rem;
                    rem_start = 1'b1;
                    rem_dvd   = {1'b0, rem} + MW'(cnt);
                    n_state   = S_REM_NX;
                end
            end
            S_REM_NX: begin
                if (rem_done) begin
                    n_next_seq = rem;
                    n_seq_ok   = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.mode)
                    gbn_pkg::MODE_SEND: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.last  = 1'b1;
                            if (cnt == FULL_CNT) begin
                                n_out.kind = gbn_pkg::KIND_REFUSED;
                            end else begin
                                n_out.kind        = gbn_pkg::KIND_SENT;
                                n_out.packet_seq  = r_next_seq;
                                n_out.packet_data = gbn_pkg::PAYLOAD_W'(
                                    r_item.payload[PAYLOAD_BITS-1:0]);
                                n_out.timer_action = (cnt == '0) ?
                                    gbn_pkg::TIMER_START : gbn_pkg::TIMER_NONE;
                                mem_we      = 1'b1;
                                n_next_slot = nslot_inc;
                                n_next_seq  = nseq_inc;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    gbn_pkg::MODE_ACK: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.last  = 1'b1;
                            if (!r_item.ack_valid) begin
                                n_out.kind = gbn_pkg::KIND_IGNORED;
                            end else begin
                                n_out.kind         = gbn_pkg::KIND_HANDLED;
                                n_out.window_moved = ack_hit;
                                n_out.timer_action = (after_oldest == r_next_slot) ?
                                    gbn_pkg::TIMER_STOP : gbn_pkg::TIMER_RESTART;
                                if (ack_hit) begin
                                    n_oldest_slot = new_oldest;
                                    n_oldest_seq  = ack_next;
                                    n_os          = ack_next;
                                end
                            end
                            n_state = S_IDLE;
                        end
                    end
                    gbn_pkg::MODE_TIMEOUT: begin
                        if (cnt == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = r_oldest_slot;
                            n_tx_slot  = r_oldest_slot;
                            n_tx_seq   = r_os;
                            n_tx_left  = cnt;
                            n_tx_first = 1'b1;
                            n_state    = S_TX;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_TX: begin
                // Emit one resent word per cycle while the output is not stalled, fetch the next slot meanwhile
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.kind         = gbn_pkg::KIND_SENT;
                    n_out.packet_seq   = r_tx_seq;
                    n_out.packet_data  = gbn_pkg::PAYLOAD_W'(mem_rdata);
                    n_out.timer_action = r_tx_first ?
                        gbn_pkg::TIMER_RESTART : gbn_pkg::TIMER_NONE;
                    n_out.last         = tx_last;
                    if (tx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = tslot_inc;
                        n_tx_slot  = tslot_inc;
                        n_tx_seq   = tseq_inc;
                        n_tx_left  = r_tx_left - 1'b1;
                        n_tx_first = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_oldest_slot <= '0;
            r_next_slot   <= '0;
            r_oldest_seq  <= '0;
            r_os          <= '0;
            r_next_seq    <= '0;
            r_seq_ok      <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_oldest_slot <= n_oldest_slot;
            r_next_slot   <= n_next_slot;
            r_oldest_seq  <= n_oldest_seq;
            r_os          <= n_os;
            r_next_seq    <= n_next_seq;
            r_seq_ok      <= n_seq_ok;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_tx_slot  <= n_tx_slot;
        r_tx_seq   <= n_tx_seq;
        r_tx_left  <= n_tx_left;
        r_tx_first <= n_tx_first;
        r_out      <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

>>> rtl/core/go_back_n_sender_window_core.sv
// Go-Back-N sender window. Payloads of unacknowledged packets are kept in a
// ring of WINDOW_SLOTS slots in one synchronous RAM; at most WINDOW_SLOTS-1
// are outstanding. A send or an ack puts one result word in the output
// register; a timeout resends every outstanding packet, read from the RAM one
// slot per cycle while the output is not stalled. For the first item after a
// write of the sequence modulus, the cached oldest and next sequence numbers
// are first reduced again by a shared bit-serial remainder unit, one dividend
// bit per cycle. A new item is taken while the last result word still waits
// at the output.
module go_back_n_sender_window_core #(
    parameter int WINDOW_SLOTS = gbn_pkg::WINDOW_SLOTS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbn_cfg_if.sink   i_cfg,
    gbn_in_if.sink    i_in,
    gbn_out_if.source o_out
);

    logic [gbn_pkg::MOD_W-1:0] r_seq_modulus;
    logic [gbn_pkg::MOD_W-1:0] modulus;
    logic                      cfg_write;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid;

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_modulus <= gbn_pkg::MOD_RESET;
        end else if (cfg_write) begin
            r_seq_modulus <= i_cfg.data;
        end
    end

    // Zero or out-of-range modulus acts as the full sequence space
    assign modulus = (r_seq_modulus == '0 || r_seq_modulus > gbn_pkg::MOD_MAX) ?
                     gbn_pkg::MOD_MAX : r_seq_modulus;

    gbn_ctrl #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_modulus     (modulus),
        .i_mod_changed (cfg_write),
        .i_in          (i_in),
        .o_out         (o_out)
    );

endmodule
